[hdl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define P1305_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define P1305_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

[hdl/p1305_pkg.sv]
// shared types, constants and state encoding for the poly1305 tag engine
`default_nettype none

package p1305_pkg;

	localparam int WordW   = 64;
	localparam int KeyW    = 128;
	localparam int MsgW    = 129;
	localparam int AccW    = 131;
	localparam int OpaW    = 132;
	localparam int CntW    = $clog2(OpaW + 1);
	localparam int CntBitW = 5;
	localparam int CfgIdxW = 4;

	localparam logic [CntBitW-1:0] MaxBytes = CntBitW'(16);

	localparam logic [WordW-1:0] ClampLow  = 64'h0fff_fffc_0fff_ffff;
	localparam logic [WordW-1:0] ClampHigh = 64'h0fff_fffc_0fff_fffc;

	typedef logic [WordW-1:0]   word_t;
	typedef logic [KeyW-1:0]    key_t;
	typedef logic [MsgW-1:0]    msg_t;
	typedef logic [AccW-1:0]    acc_t;
	typedef logic [OpaW-1:0]    opa_t;
	typedef logic [CntW-1:0]    cnt_t;
	typedef logic [CntBitW-1:0] nbytes_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam cfg_idx_t CfgRLow  = CfgIdxW'(0);
	localparam cfg_idx_t CfgRHigh = CfgIdxW'(1);
	localparam cfg_idx_t CfgSLow  = CfgIdxW'(2);
	localparam cfg_idx_t CfgSHigh = CfgIdxW'(3);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIN,
		ST_PUT
	} state_t;

endpackage

`default_nettype wire

[hdl/p1305_mul.sv]
// bit-serial multiply of the block sum by r modulo 2^130-5
`default_nettype none

module p1305_mul (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire p1305_pkg::opa_t opa,
	input  wire p1305_pkg::key_t r,
	output logic                done,
	output p1305_pkg::acc_t     prod
);

	import p1305_pkg::*;

	opa_t        a_q;
	acc_t        x_q;
	cnt_t        cnt_q;
	logic        done_q;
	logic [3:0]  fold;
	acc_t        addend;
	acc_t        x_nxt;

	// 2x drops bits 130 and 129, folded back as 5 * those bits
	always_comb begin
		fold   = {x_q[AccW-1:AccW-2], 2'b00} + {2'b00, x_q[AccW-1:AccW-2]};
		addend = a_q[OpaW-1] ? AccW'(r) : '0;
		x_nxt  = {1'b0, x_q[AccW-3:0], 1'b0} + addend + AccW'(fold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CntW'(OpaW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= opa;
			x_q <= '0;
		end else if (cnt_q != '0) begin
			a_q <= {a_q[OpaW-2:0], 1'b0};
			x_q <= x_nxt;
		end
	end

	assign done = done_q;
	assign prod = x_q;

endmodule

`default_nettype wire

[hdl/p1305_fin.sv]
// final reduction modulo 2^130-5 and addition of s
`default_nettype none

module p1305_fin (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire p1305_pkg::acc_t acc,
	input  wire p1305_pkg::key_t s,
	output logic                 done,
	output p1305_pkg::key_t      tag
);

	import p1305_pkg::*;

	acc_t         y_s1;
	logic [129:0] h_s2;
	key_t         tag_s3;
	logic         v_s1;
	logic         v_s2;
	logic         v_s3;
	acc_t         g;
	logic [2:0]   fold;

	assign fold = {acc[AccW-1], 2'b00} + {2'b00, acc[AccW-1]};
	assign g    = y_s1 + AccW'(5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_s1 <= AccW'(acc[AccW-2:0]) + AccW'(fold);
		end
		if (v_s1) begin
			// value + 5 reaching 2^130 means value >= p
			h_s2 <= g[AccW-1] ? g[AccW-2:0] : y_s1[AccW-2:0];
		end
		if (v_s2) begin
			tag_s3 <= h_s2[KeyW-1:0] + s;
		end
	end

	assign done = v_s3;
	assign tag  = tag_s3;

endmodule

`default_nettype wire

[hdl/poly1305_tag_engine_core.sv]
// a non-final block is multiplied in full before the next block can be accepted
// a final block passes the multiply and final reduction, then waits while the tag slot is full
// after a final block the next block is accepted in the cycle after the tag load at the earliest
// the multiplier shifts one bit of the 132-bit block sum per cycle
// a waiting tag stalls input only once the following tag is ready to load
// reset clears the accumulator, key registers, control state and the tag slot
`default_nettype none

module poly1305_tag_engine_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire p1305_pkg::cfg_idx_t  cfg_index,
	input  wire p1305_pkg::word_t     cfg_data,
	input  wire logic                 block_valid,
	output logic                      block_ready,
	input  wire p1305_pkg::word_t     block_low,
	input  wire p1305_pkg::word_t     block_high,
	input  wire p1305_pkg::nbytes_t   byte_count,
	input  wire logic                 last_block,
	output logic                      tag_valid,
	input  wire logic                 tag_ready,
	output p1305_pkg::word_t          tag_low,
	output p1305_pkg::word_t          tag_high
);

	import p1305_pkg::*;

	state_t  state_q;
	state_t  state_nxt;
	word_t   r_low_q;
	word_t   r_high_q;
	word_t   s_low_q;
	word_t   s_high_q;
	acc_t    acc_q;
	logic    last_q;
	logic    tag_valid_q;
	key_t    tag_q;
	nbytes_t n_eff;
	key_t    blk_data;
	msg_t    msg;
	opa_t    opa;
	key_t    r_clamped;
	logic    mul_start;
	logic    mul_done;
	acc_t    prod;
	logic    fin_start;
	logic    fin_done;
	key_t    fin_tag;
	logic    tag_load;

	// pad byte after the last data byte, bytes past the count read as zero
	always_comb begin
		n_eff    = (byte_count > MaxBytes) ? MaxBytes : byte_count;
		blk_data = {block_high, block_low};
		msg      = '0;
		for (int i = 0; i < KeyW / 8; i++) begin
			if (CntBitW'(i) < n_eff) begin
				msg[8*i +: 8] = blk_data[8*i +: 8];
			end
			if (CntBitW'(i) == n_eff) begin
				msg[8*i] = 1'b1;
			end
		end
		msg[MsgW-1] = (n_eff == MaxBytes);
		opa         = OpaW'(acc_q) + OpaW'(msg);
	end

	assign r_clamped = {r_high_q & ClampHigh, r_low_q & ClampLow};

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (block_valid) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					state_nxt = last_q ? ST_FIN : ST_IDLE;
				end
			end
			ST_FIN: begin
				if (fin_done) begin
					state_nxt = ST_PUT;
				end
			end
			ST_PUT: begin
				if (!tag_valid_q || tag_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		block_ready = 1'b0;
		mul_start   = 1'b0;
		fin_start   = 1'b0;
		tag_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				block_ready = 1'b1;
				mul_start   = block_valid;
			end
			ST_MUL: begin
				fin_start = mul_done && last_q;
			end
			ST_FIN: begin
			end
			ST_PUT: begin
				tag_load = !tag_valid_q || tag_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			r_low_q     <= '0;
			r_high_q    <= '0;
			s_low_q     <= '0;
			s_high_q    <= '0;
			acc_q       <= '0;
			last_q      <= 1'b0;
			tag_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid) begin
				case (cfg_index)
					CfgRLow:  r_low_q  <= cfg_data;
					CfgRHigh: r_high_q <= cfg_data;
					CfgSLow:  s_low_q  <= cfg_data;
					CfgSHigh: s_high_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (mul_start) begin
				last_q <= last_block;
			end
			if ((state_q == ST_MUL) && mul_done) begin
				acc_q <= last_q ? '0 : prod;
			end
			if (tag_load) begin
				tag_valid_q <= 1'b1;
			end else if (tag_ready) begin
				tag_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tag_load) begin
			tag_q <= fin_tag;
		end
	end

	p1305_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.opa    (opa),
		.r      (r_clamped),
		.done   (mul_done),
		.prod   (prod)
	);

	p1305_fin u_fin (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fin_start),
		.acc    (prod),
		.s      ({s_high_q, s_low_q}),
		.done   (fin_done),
		.tag    (fin_tag)
	);

	assign cfg_ready = 1'b1;
	assign tag_valid = tag_valid_q;
	assign tag_low   = tag_q[WordW-1:0];
	assign tag_high  = tag_q[KeyW-1:WordW];

endmodule

`default_nettype wire

[hdl/p1305_chk.sv]
// port-level checks for the poly1305 tag engine, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module p1305_chk (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             block_valid,
	input  wire logic             block_ready,
	input  wire logic             tag_valid,
	input  wire logic             tag_ready,
	input  wire p1305_pkg::word_t tag_low,
	input  wire p1305_pkg::word_t tag_high
);

	import p1305_pkg::*;

	`P1305_ASSERT_NEXT(a_tag_hold, tag_valid && !tag_ready, tag_valid && $stable(tag_low) && $stable(tag_high), "stalled tag item changed")
	`P1305_ASSERT_NEXT(a_one_block, block_valid && block_ready, !block_ready, "block accepted while previous still in work")
	`P1305_ASSERT_NEXT(a_no_early_tag, block_valid && block_ready && !tag_valid, !tag_valid, "tag appeared right after a block")
	`P1305_ASSERT(a_ready_after_tag, !$rose(tag_valid) || block_ready, "engine not idle after loading tag")

endmodule

bind poly1305_tag_engine_core p1305_chk u_chk (.*);

`default_nettype wire

[tb/sv/poly1305_tag_engine_core_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the poly1305 tag engine core: limb-level tag predictor, random idling
module poly1305_tag_engine_core_tb;
	import p1305_pkg::*;

	localparam int HoldCycles = 1500;
	localparam int SettleCycles = 200;
	localparam int StallLimit = 8000;
	localparam int PrintCap = 100;
	localparam int ItemsPerKey = 150;
	localparam logic [63:0] Mask26 = 64'h0000_0000_03ff_ffff;
	localparam cfg_idx_t CfgUnused = cfg_idx_t'(CfgSHigh + 1);
	localparam cfg_idx_t CfgTopIdx = '1;

	typedef logic [4:0][63:0] limbs_t;

	typedef struct packed {
		word_t   lo;
		word_t   hi;
		nbytes_t cnt;
		logic    last;
	} block_item_t;

	typedef struct packed {
		word_t lo;
		word_t hi;
	} tag_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_valid = 1'b0;
	cfg_idx_t cfg_index = '0;
	word_t    cfg_data = '0;
	logic     block_valid = 1'b0;
	word_t    block_low = '0;
	word_t    block_high = '0;
	nbytes_t  byte_count = '0;
	logic     last_block = 1'b0;
	logic     tag_ready = 1'b0;
	logic     cfg_ready;
	logic     block_ready;
	logic     tag_valid;
	word_t    tag_low;
	word_t    tag_high;

	block_item_t pending_blocks[$];
	tag_t        tag_expect[$];

	word_t  r_lo_key = '0;
	word_t  r_hi_key = '0;
	word_t  s_lo_key = '0;
	word_t  s_hi_key = '0;
	limbs_t poly_acc = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_tags = 1'b0;
	int hold_count = 0;
	int stall_count = 0;
	int error_count = 0;

	poly1305_tag_engine_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.block_valid (block_valid),
		.block_ready (block_ready),
		.block_low   (block_low),
		.block_high  (block_high),
		.byte_count  (byte_count),
		.last_block  (last_block),
		.tag_valid   (tag_valid),
		.tag_ready   (tag_ready),
		.tag_low     (tag_low),
		.tag_high    (tag_high)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic limbs_t split_limbs(logic [129:0] v);
		limbs_t l;
		for (int i = 0; i < 5; i++) begin
			l[i] = 64'(v[26*i +: 26]);
		end
		return l;
	endfunction

	// accumulate one block into poly_acc; returns 1 with the tag on a final block
	function automatic logic absorb_block(word_t lo, word_t hi, nbytes_t cnt, logic last,
			output tag_t tag);
		logic [129:0] msg;
		limbs_t m;
		limbs_t r;
		limbs_t a;
		limbs_t d;
		limbs_t g;
		logic [63:0] c;
		word_t tlo;
		word_t thi;
		word_t sum;
		int n;
		tag = '0;
		if (cnt > MaxBytes) begin
			n = 16;
		end else begin
			n = int'(cnt);
		end
		msg = {2'b00, hi, lo};
		if (n < 16) begin
			msg = (msg & ((130'd1 << (8 * n)) - 130'd1)) | (130'd1 << (8 * n));
		end else begin
			msg[128] = 1'b1;
		end
		m = split_limbs(msg);
		r = split_limbs({2'b00, r_hi_key & ClampHigh, r_lo_key & ClampLow});
		for (int i = 0; i < 5; i++) begin
			a[i] = poly_acc[i] + m[i];
		end
		d[0] = a[0]*r[0] + 64'd5*(a[1]*r[4] + a[2]*r[3] + a[3]*r[2] + a[4]*r[1]);
		d[1] = a[0]*r[1] + a[1]*r[0] + 64'd5*(a[2]*r[4] + a[3]*r[3] + a[4]*r[2]);
		d[2] = a[0]*r[2] + a[1]*r[1] + a[2]*r[0] + 64'd5*(a[3]*r[4] + a[4]*r[3]);
		d[3] = a[0]*r[3] + a[1]*r[2] + a[2]*r[1] + a[3]*r[0] + 64'd5*(a[4]*r[4]);
		d[4] = a[0]*r[4] + a[1]*r[3] + a[2]*r[2] + a[3]*r[1] + a[4]*r[0];
		for (int i = 0; i < 4; i++) begin
			d[i+1] = d[i+1] + (d[i] >> 26);
			d[i] = d[i] & Mask26;
		end
		c = d[4] >> 26;
		d[4] = d[4] & Mask26;
		d[0] = d[0] + c * 64'd5;
		c = d[0] >> 26;
		d[0] = d[0] & Mask26;
		d[1] = d[1] + c;
		poly_acc = d;
		if (!last) begin
			return 1'b0;
		end
		// full carry, then subtract p when the value is at least p
		for (int p = 0; p < 3; p++) begin
			for (int i = 0; i < 4; i++) begin
				d[i+1] = d[i+1] + (d[i] >> 26);
				d[i] = d[i] & Mask26;
			end
			c = d[4] >> 26;
			d[4] = d[4] & Mask26;
			d[0] = d[0] + c * 64'd5;
		end
		g[0] = d[0] + 64'd5;
		for (int i = 0; i < 4; i++) begin
			g[i+1] = d[i+1] + (g[i] >> 26);
			g[i] = g[i] & Mask26;
		end
		if (g[4][26]) begin
			g[4] = g[4] & Mask26;
			d = g;
		end
		tlo = d[0] | (d[1] << 26) | (d[2] << 52);
		thi = (d[2] >> 12) | (d[3] << 14) | (d[4] << 40);
		sum = tlo + s_lo_key;
		tag.lo = sum;
		tag.hi = thi + s_hi_key + ((sum < tlo) ? 64'd1 : 64'd0);
		poly_acc = '0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(string msg);
		if (error_count < PrintCap) begin
			$display("%0t mismatch: %s", $realtime, msg);
		end
		error_count++;
	endtask

	// block driver
	always @(posedge clk or negedge arst_n) begin : drive_blocks
		block_item_t nxt;
		tag_t tag;
		if (!arst_n) begin
			block_valid <= 1'b0;
		end else begin
			if (block_valid && block_ready) begin
				if (absorb_block(block_low, block_high, byte_count, last_block, tag)) begin
					tag_expect.push_back(tag);
				end
			end
			if (!block_valid || block_ready) begin
				if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_blocks.pop_front();
					block_valid <= 1'b1;
					block_low <= nxt.lo;
					block_high <= nxt.hi;
					byte_count <= nxt.cnt;
					last_block <= nxt.last;
				end else begin
					block_valid <= 1'b0;
				end
			end
		end
	end

	// tag monitor
	always @(posedge clk or negedge arst_n) begin : watch_tags
		tag_t want;
		if (!arst_n) begin
			tag_ready <= 1'b0;
			hold_count <= 0;
		end else begin
			if (tag_valid && tag_ready) begin
				if (tag_expect.size() == 0) begin
					report_mismatch($sformatf("tag %h_%h with none expected", tag_high, tag_low));
				end else begin
					want = tag_expect.pop_front();
					if (tag_low !== want.lo) begin
						report_mismatch($sformatf("tag_low %h, want %h", tag_low, want.lo));
					end
					if (tag_high !== want.hi) begin
						report_mismatch($sformatf("tag_high %h, want %h", tag_high, want.hi));
					end
				end
			end
			if (hold_tags && hold_count < HoldCycles) begin
				hold_count <= hold_count + 1;
				tag_ready <= 1'b0;
			end else begin
				tag_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_count <= 0;
		end else if ((block_valid && block_ready) || (tag_valid && tag_ready) ||
				(cfg_valid && cfg_ready)) begin
			stall_count <= 0;
		end else if (stall_count >= StallLimit) begin
			$display("[poly1305_tag_engine_core] ERROR");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic word_t key_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return rand_word();
		endcase
	endfunction

	task automatic push_block(word_t lo, word_t hi, nbytes_t cnt, logic last);
		block_item_t it;
		it.lo = lo;
		it.hi = hi;
		it.cnt = cnt;
		it.last = last;
		pending_blocks.push_back(it);
	endtask

	task automatic write_reg(cfg_idx_t idx, word_t data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CfgRLow: r_lo_key = data;
			CfgRHigh: r_hi_key = data;
			CfgSLow: s_lo_key = data;
			CfgSHigh: s_hi_key = data;
			default: ;
		endcase
	endtask

	task automatic load_key(word_t rl, word_t rh, word_t sl, word_t sh);
		write_reg(CfgRLow, rl);
		write_reg(CfgRHigh, rh);
		write_reg(CfgSLow, sl);
		write_reg(CfgSHigh, sh);
	endtask

	// sender pause until every tag is back, then let any trailing block finish
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_blocks.size() != 0 || block_valid || tag_expect.size() != 0);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// mostly well-formed messages, some odd counts and stray last flags
	task automatic queue_random(int items);
		int left;
		int nb;
		left = items;
		while (left > 0) begin
			if ($urandom_range(9) == 0) begin
				push_block(rand_word(), rand_word(), nbytes_t'($urandom_range(31)),
					1'($urandom_range(1)));
				left--;
			end else begin
				nb = $urandom_range(1, 4);
				for (int b = 0; b < nb; b++) begin
					if (b == nb - 1) begin
						push_block(rand_word(), rand_word(), nbytes_t'($urandom_range(1, 16)), 1'b1);
					end else begin
						push_block(rand_word(), rand_word(), MaxBytes, 1'b0);
					end
				end
				left -= nb;
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero key after reset gives all-zero tags
		push_block('1, '1, MaxBytes, 1'b0);
		push_block('1, '1, nbytes_t'(5), 1'b1);
		wait_idle();

		// writes to unused indexes leave the key alone
		write_reg(CfgUnused, '1);
		write_reg(CfgTopIdx, '1);
		push_block(rand_word(), rand_word(), MaxBytes, 1'b1);
		wait_idle();

		load_key('1, '1, '1, '1);
		for (int n = 0; n <= 17; n++) begin
			push_block('1, '1, nbytes_t'(n), n % 4 == 3);
		end
		push_block('1, '1, '1, 1'b1);
		push_block('0, '0, MaxBytes, 1'b1);
		wait_idle();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 35;
					recv_idle_pct = 64;
				end
				1: begin
					send_idle_pct = 64;
					recv_idle_pct = 35;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 3; seg++) begin
				load_key(key_word(), key_word(), key_word(), key_word());
				if (ph == 2 && seg == 0) begin
					hold_tags = 1'b1;
				end
				queue_random(ItemsPerKey);
				wait_idle();
			end
		end

		if (error_count == 0) begin
			$display("[poly1305_tag_engine_core] OK");
		end else begin
			$display("[poly1305_tag_engine_core] ERROR");
		end
		$finish;
	end

endmodule

[poly1305_tag_engine_core.f]
+incdir+hdl
hdl/p1305_pkg.sv
hdl/p1305_mul.sv
hdl/p1305_fin.sv
hdl/poly1305_tag_engine_core.sv
hdl/p1305_chk.sv
tb/sv/poly1305_tag_engine_core_tb.sv
